// File: rtl/multi_channel_trailing_debounce_defines.svh
`ifndef MULTI_CHANNEL_TRAILING_DEBOUNCE_DEFINES_SVH
`define MULTI_CHANNEL_TRAILING_DEBOUNCE_DEFINES_SVH

// checks sampled on clk, masked while rst is high
`define MCTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checks sampled on clk, active during reset as well
`define MCTD_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/mctd_pkg.sv
package mctd_pkg;

  localparam int CHANNELS    = 8;
  localparam int NUM_DELAY   = 8;
  localparam int CH_W        = 3;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 16;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_PAD_W    = IN_TDATA_W - CH_W - VAL_W;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - CH_W - VAL_W;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_FORCE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] val;
    logic             last;
  } result_t;

  typedef struct packed {
    logic             ge;
    logic             eq;
    logic [CNT_W-1:0] count;
  } cmp_t;

endpackage

// File: rtl/mctd_unit.sv
module mctd_unit (
  input  logic                    scan,
  input  logic [mctd_pkg::VAL_W-1:0] a_word,
  input  logic [mctd_pkg::VAL_W-1:0] b_word,
  output mctd_pkg::cmp_t          res
);
  import mctd_pkg::*;

  logic [CNT_W-1:0] count_inc;
  logic [VAL_W-1:0] cmp_a;

  // saturating advance of the elapsed count
  always_comb begin
    if (&a_word[CNT_W-1:0]) begin
      count_inc = a_word[CNT_W-1:0];
    end else begin
      count_inc = a_word[CNT_W-1:0] + CNT_W'(1);
    end
    cmp_a     = scan ? VAL_W'(count_inc) : a_word;
    res.ge    = cmp_a >= b_word;
    res.eq    = cmp_a == b_word;
    res.count = count_inc;
  end

endmodule

// File: rtl/mctd_out.sv
module mctd_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  mctd_pkg::result_t               push_data,
  output logic                            free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mctd_pkg::OUT_TDATA_W-1:0] m_tdata,  // fired_channel, fired_value, zero pad
  output logic                            m_tlast   // last_of_run
);
  import mctd_pkg::*;

  result_t data;

  assign free    = !m_tvalid || m_tready;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, data.val, data.ch};
  assign m_tlast = data.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

endmodule

// File: rtl/multi_channel_trailing_debounce.sv
// Update or forced update: accept, then compare and write back.
// Tick: accept, one channel per cycle unless a firing waits on output, final flush.
// A forced update or a tick runs longer while the result register is held by m_tready low.
// One item in flight: the next transfer is taken the cycle after the item ends.
// One shared compare unit serves both the value check and the delay check.
// Reset (rst, synchronous) clears all values, counts, armed bits and delays.
module multi_channel_trailing_debounce (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mctd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mctd_pkg::CNT_W-1:0]       cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mctd_pkg::IN_TDATA_W-1:0]  s_tdata,   // channel, new_value, zero pad
  input  logic [mctd_pkg::OP_W-1:0]        s_tuser,   // operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mctd_pkg::OUT_TDATA_W-1:0] m_tdata,   // fired_channel, fired_value, zero pad
  output logic                             m_tlast    // last_of_run
);
  import mctd_pkg::*;

  state_t            state, state_next;
  op_t               op_q;
  logic [CH_W-1:0]   ch_q;
  logic [VAL_W-1:0]  val_q;
  logic [CH_W-1:0]   idx;
  result_t           pend;
  logic              pend_valid;

  logic [VAL_W-1:0]  held    [CHANNELS];
  logic [CNT_W-1:0]  elapsed [CHANNELS];
  logic [CNT_W-1:0]  delay   [NUM_DELAY];
  logic [CHANNELS-1:0] armed;

  logic [CH_W-1:0]   rd_ch;
  logic              scan;
  logic [VAL_W-1:0]  a_word, b_word;
  cmp_t              cmp;
  logic              free, push, fire, step, store, arm, disarm;
  result_t           push_data;

  assign scan   = state == ST_SCAN;
  assign rd_ch  = scan ? idx : ch_q;
  assign a_word = scan ? VAL_W'(elapsed[idx]) : held[rd_ch];
  assign b_word = scan ? VAL_W'(delay[idx]) : val_q;
  assign fire   = scan && armed[idx] && cmp.ge;

  mctd_unit u_unit (
    .scan   (scan),
    .a_word (a_word),
    .b_word (b_word),
    .res    (cmp)
  );

  mctd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .free      (free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    push       = 1'b0;
    push_data  = pend;
    step       = 1'b0;
    store      = 1'b0;
    arm        = 1'b0;
    disarm     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (op_t'(s_tuser) == OP_TICK) ? ST_SCAN : ST_UPD;
        end
      end
      ST_UPD: begin
        priority if (int'(ch_q) >= CHANNELS || cmp.eq) begin
          state_next = ST_IDLE;
        end else if (op_q == OP_UPDATE) begin
          store      = 1'b1;
          arm        = 1'b1;
          state_next = ST_IDLE;
        end else if (op_q == OP_FORCE) begin
          if (free) begin
            store      = 1'b1;
            disarm     = 1'b1;
            push       = 1'b1;
            push_data  = '{ch: ch_q, val: val_q, last: 1'b1};
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // hold while a second firing waits on a full result register
        if (!(fire && pend_valid && !free)) begin
          step = 1'b1;
          if (fire && pend_valid) begin
            push      = 1'b1;
            push_data = '{ch: pend.ch, val: pend.val, last: 1'b0};
          end
          if (idx == CH_W'(CHANNELS - 1)) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (free) begin
          push       = 1'b1;
          push_data  = '{ch: pend.ch, val: pend.val, last: 1'b1};
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q       <= OP_TICK;
      ch_q       <= '0;
      val_q      <= '0;
      idx        <= '0;
      pend       <= '0;
      pend_valid <= 1'b0;
      armed      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        held[i]    <= '0;
        elapsed[i] <= '0;
      end
      for (int i = 0; i < NUM_DELAY; i++) begin
        delay[i] <= '0;
      end
    end else begin
      if (cfg_we && int'(cfg_index) < NUM_DELAY) begin
        delay[cfg_index[CH_W-1:0]] <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        op_q       <= op_t'(s_tuser);
        ch_q       <= s_tdata[CH_W-1:0];
        val_q      <= s_tdata[CH_W +: VAL_W];
        idx        <= '0;
        pend_valid <= 1'b0;
      end
      if (step) begin
        if (armed[idx]) begin
          elapsed[idx] <= cmp.count;
        end
        if (fire) begin
          armed[idx] <= 1'b0;
          pend       <= '{ch: idx, val: held[idx], last: 1'b0};
          pend_valid <= 1'b1;
        end
        idx <= idx + CH_W'(1);
      end
      if (store) begin
        held[ch_q] <= val_q;
      end
      if (arm) begin
        elapsed[ch_q] <= '0;
        armed[ch_q]   <= 1'b1;
      end
      if (disarm) begin
        armed[ch_q] <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/mctd_chk.sv
`include "multi_channel_trailing_debounce_defines.svh"

module mctd_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [mctd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tlast
);
  import mctd_pkg::*;

  `MCTD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
  `MCTD_ASSERT_NR(a_out_reset, rst |=> !m_tvalid, "result valid after reset")
  `MCTD_ASSERT(a_busy, s_tvalid && s_tready |=> !s_tready, "input taken while busy")
  `MCTD_ASSERT(a_pad, m_tvalid |-> m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] == '0, "result pad not zero")

endmodule

bind multi_channel_trailing_debounce mctd_chk u_chk (.*);

// File: dv/debounce_checker.sv
module debounce_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mctd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mctd_pkg::CNT_W-1:0]       cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [mctd_pkg::IN_TDATA_W-1:0]  s_tdata,   // channel, new_value, zero pad
  input  logic [mctd_pkg::OP_W-1:0]        s_tuser,   // operation
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [mctd_pkg::OUT_TDATA_W-1:0] m_tdata,   // fired_channel, fired_value, zero pad
  input  logic                             m_tlast,   // last_of_run
  output int                               errors,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mctd_pkg::*;

  logic [VAL_W-1:0] held [CHANNELS];
  logic             armed [CHANNELS];
  logic [CNT_W-1:0] elapsed [CHANNELS];
  logic [CNT_W-1:0] delay_ticks [NUM_DELAY];
  result_t          fired_q [$];

  task automatic advance_table(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                               input logic [VAL_W-1:0] val);
    result_t             r;
    logic [CHANNELS-1:0] fire;
    int                  top_ch;
    fire = '0;
    top_ch = -1;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (armed[i]) begin
            if (elapsed[i] != '1) elapsed[i] = elapsed[i] + 1'b1;
            if (elapsed[i] >= delay_ticks[i]) begin
              armed[i] = 1'b0;
              fire[i] = 1'b1;
              top_ch = i;
            end
          end
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (fire[i]) begin
            r.ch = i[CH_W-1:0];
            r.val = held[i];
            r.last = (i == top_ch);
            fired_q = {fired_q, r};
          end
        end
      end
      OP_UPDATE, OP_FORCE: begin
        if (held[ch] != val) begin
          held[ch] = val;
          if (op == OP_UPDATE) begin
            elapsed[ch] = '0;
            armed[ch] = 1'b1;
          end else begin
            armed[ch] = 1'b0;
            r.ch = ch;
            r.val = val;
            r.last = 1'b1;
            fired_q = {fired_q, r};
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic match_result(input logic [CH_W-1:0] ch, input logic [VAL_W-1:0] val,
                              input logic last);
    result_t want;
    if (fired_q.size() == 0) begin
      errors = errors + 1;
      $display("%0t: unexpected transfer ch=%0d val=%h last=%b", $time, ch, val, last);
    end else begin
      want = fired_q.pop_front();
      if (want.ch !== ch || want.val !== val || want.last !== last) begin
        errors = errors + 1;
        $display("%0t: mismatch expected ch=%0d val=%h last=%b, actual ch=%0d val=%h last=%b",
                 $time, want.ch, want.val, want.last, ch, val, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        held[i] = '0;
        armed[i] = 1'b0;
        elapsed[i] = '0;
      end
      for (int i = 0; i < NUM_DELAY; i++) delay_ticks[i] = '0;
      fired_q.delete();
    end else begin
      if (m_tvalid && m_tready)
        match_result(m_tdata[CH_W-1:0], m_tdata[CH_W+VAL_W-1:CH_W], m_tlast);
      if (cfg_we && cfg_index < NUM_DELAY)
        delay_ticks[cfg_index[CH_W-1:0]] = cfg_data;
      if (s_tvalid && s_tready)
        advance_table(s_tuser, s_tdata[CH_W-1:0], s_tdata[CH_W+VAL_W-1:CH_W]);
    end
    pending = fired_q.size();
  end

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mctd_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 75;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CNT_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]        s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  int               errors;
  int               pending;
  int               idle_cycles = 0;
  int               rx_gap;
  bit               steady;
  bit               hold_req;
  logic [VAL_W-1:0] last_val [CHANNELS];
  logic [CNT_W-1:0] plan [NUM_DELAY];

  multi_channel_trailing_debounce uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  debounce_checker tracker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                       input logic [VAL_W-1:0] val);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{IN_PAD_W{1'b0}}, val, ch};
    if (op == OP_UPDATE || op == OP_FORCE) last_val[ch] = val;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CHANNELS + 6) @(negedge clk);
  endtask

  task automatic load_delays();
    for (int i = 0; i < NUM_DELAY; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= plan[i];
      @(negedge clk);
    end
    // out-of-range index, must be dropped
    cfg_index <= CFG_IDX_W'($urandom_range(NUM_DELAY, 2 ** CFG_IDX_W - 1));
    cfg_data <= CNT_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int               done_items;
    int               r;
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] val;
    done_items = 0;
    while (done_items < count) begin
      ch = CH_W'($urandom_range(0, CHANNELS - 1));
      r = $urandom_range(0, 99);
      op = (r < 40) ? OP_TICK : (r < 80) ? OP_UPDATE : (r < 94) ? OP_FORCE : OP_SPARE;
      r = $urandom_range(0, 99);
      if (r < 30) val = last_val[ch];
      else if (r < 38) val = '0;
      else if (r < 46) val = '1;
      else if (r < 56) val = 32'h1 << $urandom_range(0, 31);
      else val = $urandom;
      done_items++;
      offer(op, ch, val);
    end
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (steady) begin
        m_tready <= 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 99) < 60) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        rx_gap = gap_len();
        repeat (rx_gap + 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_TICK;
    steady = 1'b0;
    hold_req = 1'b0;
    for (int i = 0; i < CHANNELS; i++) last_val[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    plan = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    load_delays();
    offer(OP_TICK, 3'd0, '0);
    offer(OP_FORCE, 3'd0, '0);
    offer(OP_UPDATE, 3'd0, '1);
    offer(OP_UPDATE, 3'd1, 32'h0000_0001);
    offer(OP_UPDATE, 3'd2, 32'h8000_0000);
    for (int i = 3; i < 7; i++) offer(OP_UPDATE, i[CH_W-1:0], $urandom);
    offer(OP_UPDATE, 3'd7, 32'hFFFF_FFFE);
    offer(OP_TICK, 3'd7, '1);
    offer(OP_SPARE, 3'd7, '1);
    offer(OP_FORCE, 3'd6, '0);
    drain();

    plan = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'hFFFE, 16'd1, 16'd2};
    load_delays();
    offer(OP_UPDATE, 3'd1, 32'h5A5A_5A5A);
    offer(OP_UPDATE, 3'd3, 32'hA5A5_A5A5);
    offer(OP_UPDATE, 3'd4, 32'h1234_5678);
    offer(OP_UPDATE, 3'd2, 32'h0F0F_0F0F);
    offer(OP_TICK, 3'd0, '0);
    // same word again: count keeps running, channel stays armed
    offer(OP_UPDATE, 3'd3, 32'hA5A5_A5A5);
    offer(OP_FORCE, 3'd2, 32'h0F0F_0F0F);
    offer(OP_TICK, 3'd0, '0);
    offer(OP_TICK, 3'd0, '0);
    offer(OP_UPDATE, 3'd7, 32'hDEAD_BEEF);
    offer(OP_FORCE, 3'd7, 32'hCAFE_F00D);
    offer(OP_TICK, 3'd0, '0);
    offer(OP_TICK, 3'd0, '0);
    drain();

    for (int i = 0; i < NUM_DELAY; i++) plan[i] = CNT_W'($urandom_range(0, 3));
    load_delays();
    run_random(PHASE_ITEMS);
    drain();

    for (int i = 0; i < NUM_DELAY; i++) plan[i] = CNT_W'($urandom_range(0, 5));
    plan[2] = '1;
    plan[5] = 16'hFFFE;
    load_delays();
    hold_req = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    for (int i = 0; i < NUM_DELAY; i++) plan[i] = CNT_W'($urandom_range(0, 6));
    plan[$urandom_range(0, NUM_DELAY - 1)] = CNT_W'($urandom);
    load_delays();
    run_random(PHASE_ITEMS);
    drain();

    for (int i = 0; i < NUM_DELAY; i++) plan[i] = CNT_W'($urandom_range(0, 2));
    load_delays();
    steady = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/mctd_pkg.sv
rtl/mctd_unit.sv
rtl/mctd_out.sv
rtl/multi_channel_trailing_debounce.sv
rtl/mctd_chk.sv
dv/debounce_checker.sv
dv/testbench.sv
